// ----- design/slp_pkg.sv -----
// ----------------------------------------------------------------------------
// slp_pkg
// Types and constants shared by the stage latency profiler modules.
// ----------------------------------------------------------------------------
package slp_pkg;

  localparam int unsigned NUM_STATS = 17;
  localparam int unsigned NUM_LAT   = 5;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned STAT_W    = 64;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_AW    = 2;

  // operation codes
  localparam logic [2:0] OP_RECV      = 3'd0;
  localparam logic [2:0] OP_DEC_BEGIN = 3'd1;
  localparam logic [2:0] OP_DEC_END   = 3'd2;
  localparam logic [2:0] OP_HND_BEGIN = 3'd3;
  localparam logic [2:0] OP_HND_END   = 3'd4;
  localparam logic [2:0] OP_REPORT    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_PAYLOAD_MIN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SLOW_A      = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SLOW_B      = 2'd2;

  localparam logic [15:0]     PAYLOAD_MIN_RST = 16'd128;
  localparam logic [TS_W-1:0] SLOW_A_RST      = 32'd16667;
  localparam logic [TS_W-1:0] SLOW_B_RST      = 32'd33333;

  // statistic indexes
  localparam logic [IDX_W-1:0] ST_FRAMES    = 5'd0;
  localparam logic [IDX_W-1:0] ST_ERRORS    = 5'd1;
  localparam logic [IDX_W-1:0] ST_UNM_DEC   = 5'd2;
  localparam logic [IDX_W-1:0] ST_UNM_HND   = 5'd3;
  localparam logic [IDX_W-1:0] ST_OVERWRITE = 5'd4;
  localparam logic [IDX_W-1:0] ST_SUM_BASE  = 5'd5;
  localparam logic [IDX_W-1:0] ST_SUM_LAST  = 5'd9;
  localparam logic [IDX_W-1:0] ST_MAX_BASE  = 5'd10;
  localparam logic [IDX_W-1:0] ST_MAX_LAST  = 5'd14;
  localparam logic [IDX_W-1:0] ST_SLOW_A    = 5'd15;
  localparam logic [IDX_W-1:0] ST_SLOW_B    = 5'd16;

  typedef struct packed {
    logic [2:0]         operation;
    logic [TS_W-1:0]    timestamp_us;
    logic [15:0]        request_bytes;
    logic signed [15:0] transfer_count;
    logic               from_receiver;
    logic               failed;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  stat_index;
    logic [STAT_W-1:0] stat_value;
    logic              last_item;
  } out_word_t;

  // work handed to the statistics engine
  typedef struct packed {
    logic                           report;
    logic [NUM_STATS-1:0]           mask;
    logic [NUM_LAT-1:0][TS_W-1:0]   lat;
  } slp_job_t;

endpackage

// ----- design/slp_stat_engine.sv -----
// ----------------------------------------------------------------------------
// slp_stat_engine
// Statistics store: one 17 x 64 memory, updated by read-modify-write, one
// entry per cycle unless a report word stalls; streamed out and cleared on a report.
// ----------------------------------------------------------------------------
module slp_stat_engine
  import slp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  slp_job_t  job,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic [STAT_W-1:0] mem [NUM_STATS];

  logic [NUM_STATS-1:0]         ent_vld_r;
  logic [NUM_STATS-1:0]         mask_r;
  logic                         rpt_r;
  logic [NUM_LAT-1:0][TS_W-1:0] lat_r;

  logic [STAT_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic              w_vld_r;
  logic [IDX_W-1:0]  w_idx_r;

  logic      out_valid_r;
  out_word_t out_word_r;

  logic              adv;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic [STAT_W-1:0] old_val;
  logic [STAT_W-1:0] wr_data;
  logic [IDX_W-1:0]  lat_off;
  logic [TS_W-1:0]   lat_sel;

  // hold the write stage while a report word waits at the output
  assign adv = !(w_vld_r && rpt_r && out_valid_r && !out_ready);

  always_comb begin
    rd_idx = '0;
    for (int i = NUM_STATS - 1; i >= 0; i--) begin
      if (mask_r[i]) rd_idx = IDX_W'(i);
    end
  end

  assign rd_en = adv && (mask_r != '0);

  always_comb begin
    old_val = rd_vld_r ? rd_data_r : '0;
    lat_off = (w_idx_r <= ST_SUM_LAST) ? (w_idx_r - ST_SUM_BASE) : (w_idx_r - ST_MAX_BASE);
    lat_sel = lat_r[lat_off[2:0]];
    if (rpt_r) begin
      wr_data = '0;
    end else if (w_idx_r >= ST_SUM_BASE && w_idx_r <= ST_SUM_LAST) begin
      wr_data = old_val + {32'd0, lat_sel};
    end else if (w_idx_r >= ST_MAX_BASE && w_idx_r <= ST_MAX_LAST) begin
      wr_data = (lat_sel > old_val[TS_W-1:0]) ? {32'd0, lat_sel} : old_val;
    end else begin
      wr_data = {32'd0, old_val[TS_W-1:0] + 32'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
    if (w_vld_r && adv) begin
      mem[w_idx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r   <= '0;
      mask_r      <= '0;
      rpt_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      w_vld_r     <= 1'b0;
      w_idx_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        mask_r <= job.mask;
        rpt_r  <= job.report;
        lat_r  <= job.lat;
      end else if (rd_en) begin
        mask_r[rd_idx] <= 1'b0;
      end
      if (adv) begin
        w_vld_r <= rd_en;
        if (rd_en) begin
          w_idx_r  <= rd_idx;
          rd_vld_r <= ent_vld_r[rd_idx];
        end
        if (w_vld_r) begin
          ent_vld_r[w_idx_r] <= 1'b1;
        end
      end
      if (w_vld_r && rpt_r && adv) begin
        out_valid_r           <= 1'b1;
        out_word_r.stat_index <= w_idx_r;
        out_word_r.stat_value <= old_val;
        out_word_r.last_item  <= (w_idx_r == ST_SLOW_B);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign busy      = (mask_r != '0) || w_vld_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- design/stage_latency_profiler.sv -----
// ----------------------------------------------------------------------------
// stage_latency_profiler
// Tracks a frame through receive, decrypt and handover stages and keeps
// event counts and latency sums/maxima; a report streams 17 words.
// ----------------------------------------------------------------------------
// Timing: an event that changes no statistic (receive, ignored events)
// starts no engine work. Otherwise the statistics memory is walked one
// entry per cycle with a read-modify-write pipeline, held while a report
// word waits at the output, and in_ready stays low until every statistic
// the event touches is written. Reset needs no clearing pass: per-entry
// valid bits make fresh entries read zero.
module stage_latency_profiler
  import slp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [15:0]     payload_min_r;
  logic [TS_W-1:0] slow_a_r;
  logic [TS_W-1:0] slow_b_r;

  logic [TS_W-1:0]      pend_r, pend_nxt;
  logic [3:0][TS_W-1:0] st_r, st_nxt;
  logic dec_act_r, dec_act_nxt;
  logic dec_rdy_r, dec_rdy_nxt;
  logic hnd_act_r, hnd_act_nxt;

  logic     accept;
  logic     busy;
  logic     start;
  slp_job_t job;
  logic     cnt_pos;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign cnt_pos  = in_word.transfer_count > 16'sd0;

  always_comb begin
    pend_nxt    = pend_r;
    st_nxt      = st_r;
    dec_act_nxt = dec_act_r;
    dec_rdy_nxt = dec_rdy_r;
    hnd_act_nxt = hnd_act_r;
    job.report  = 1'b0;
    job.mask    = '0;
    job.lat[0]  = st_r[1] - st_r[0];
    job.lat[1]  = st_r[2] - st_r[1];
    job.lat[2]  = st_r[3] - st_r[2];
    job.lat[3]  = in_word.timestamp_us - st_r[3];
    job.lat[4]  = in_word.timestamp_us - st_r[0];
    unique case (in_word.operation)
      OP_RECV: begin
        if (in_word.request_bytes > payload_min_r && cnt_pos && in_word.from_receiver)
          pend_nxt = in_word.timestamp_us;
      end
      OP_DEC_BEGIN: begin
        if (dec_act_r || dec_rdy_r || hnd_act_r) job.mask[ST_OVERWRITE] = 1'b1;
        if (pend_r == '0) begin
          job.mask[ST_UNM_DEC] = 1'b1;
          dec_act_nxt          = 1'b0;
        end else begin
          st_nxt[0]   = pend_r;
          st_nxt[1]   = in_word.timestamp_us;
          pend_nxt    = '0;
          dec_act_nxt = 1'b1;
          dec_rdy_nxt = 1'b0;
          hnd_act_nxt = 1'b0;
        end
      end
      OP_DEC_END: begin
        if (dec_act_r) begin
          st_nxt[2]   = in_word.timestamp_us;
          dec_act_nxt = 1'b0;
          dec_rdy_nxt = !in_word.failed;
          job.mask[ST_ERRORS] = in_word.failed;
        end
      end
      OP_HND_BEGIN: begin
        if (!dec_rdy_r) begin
          job.mask[ST_UNM_HND] = 1'b1;
          hnd_act_nxt          = 1'b0;
        end else begin
          st_nxt[3]   = in_word.timestamp_us;
          dec_rdy_nxt = 1'b0;
          hnd_act_nxt = 1'b1;
        end
      end
      OP_HND_END: begin
        if (hnd_act_r) begin
          job.mask[ST_FRAMES] = 1'b1;
          for (int i = 0; i < NUM_LAT; i++) begin
            job.mask[int'(ST_SUM_BASE) + i] = 1'b1;
            job.mask[int'(ST_MAX_BASE) + i] = 1'b1;
          end
          job.mask[ST_SLOW_A] = job.lat[4] > slow_a_r;
          job.mask[ST_SLOW_B] = job.lat[4] > slow_b_r;
          hnd_act_nxt = 1'b0;
        end
      end
      OP_REPORT: begin
        job.report = 1'b1;
        job.mask   = '1;
      end
      default: begin
      end
    endcase
  end

  assign start = accept && (job.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_min_r <= PAYLOAD_MIN_RST;
      slow_a_r      <= SLOW_A_RST;
      slow_b_r      <= SLOW_B_RST;
      pend_r        <= '0;
      st_r          <= '0;
      dec_act_r     <= 1'b0;
      dec_rdy_r     <= 1'b0;
      hnd_act_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PAYLOAD_MIN: payload_min_r <= cfg_wdata[15:0];
          CFG_SLOW_A:      slow_a_r      <= cfg_wdata;
          CFG_SLOW_B:      slow_b_r      <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        pend_r    <= pend_nxt;
        st_r      <= st_nxt;
        dec_act_r <= dec_act_nxt;
        dec_rdy_r <= dec_rdy_nxt;
        hnd_act_r <= hnd_act_nxt;
      end
    end
  end

  slp_stat_engine u_stat (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .job       (job),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stage_latency_profiler. A short table of directed
// events is followed by randomized frame sequences under several register
// settings. Every report word is checked in order against a predictor of the stage
// machine and statistics. Channels idle and stall at random, bar the last segment.
// ----------------------------------------------------------------------------
module tb;
  import slp_pkg::*;

  localparam int PLAN_LEN      = 27;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    in_word_t                              w;
    logic                                  typed;
    logic [NUM_STATS-1:0][STAT_W-1:0]      stats;
  } plan_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_word   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_word;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // register copies
  logic [15:0]     cfg_min_bytes = PAYLOAD_MIN_RST;
  logic [TS_W-1:0] cfg_slow_a    = SLOW_A_RST;
  logic [TS_W-1:0] cfg_slow_b    = SLOW_B_RST;

  // predicted stage machine and statistics
  logic [TS_W-1:0]   rx_pending = '0;
  logic [TS_W-1:0]   stamp [4];
  logic              dec_busy   = 1'b0;
  logic              dec_done   = 1'b0;
  logic              hnd_busy   = 1'b0;
  logic [STAT_W-1:0] stat_acc [NUM_STATS];

  out_word_t stat_words_due [$];
  int        mismatches   = 0;
  int        snd_idle_pct = 12;
  int        rcv_idle_pct = 70;
  logic [TS_W-1:0] now_us = '0;

  // directed rows may carry a typed-in report
  logic                             typed_now   = 1'b0;
  logic [NUM_STATS-1:0][STAT_W-1:0] typed_stats = '0;
  plan_row_t plan [PLAN_LEN];
  int        plan_len = 0;

  stage_latency_profiler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  function automatic in_word_t ev(logic [2:0] op, logic [TS_W-1:0] ts, logic [15:0] req,
                                  logic [15:0] cnt, logic rx, logic fl);
    in_word_t w;
    w.operation      = op;
    w.timestamp_us   = ts;
    w.request_bytes  = req;
    w.transfer_count = cnt;
    w.from_receiver  = rx;
    w.failed         = fl;
    return w;
  endfunction

  // event counters wrap at 32 bits
  function automatic void bump(logic [IDX_W-1:0] idx);
    stat_acc[idx] = {32'b0, stat_acc[idx][31:0] + 32'd1};
  endfunction

  function automatic void profile_event(in_word_t w);
    logic [TS_W-1:0] lat [NUM_LAT];
    out_word_t       sw;
    case (w.operation)
      OP_RECV: begin
        if (w.request_bytes > cfg_min_bytes && $signed(w.transfer_count) > 16'sd0 &&
            w.from_receiver)
          rx_pending = w.timestamp_us;
      end
      OP_DEC_BEGIN: begin
        if (dec_busy || dec_done || hnd_busy) bump(ST_OVERWRITE);
        if (rx_pending == '0) begin
          bump(ST_UNM_DEC);
          dec_busy = 1'b0;
        end else begin
          stamp[0]   = rx_pending;
          rx_pending = '0;
          stamp[1]   = w.timestamp_us;
          dec_busy   = 1'b1;
          dec_done   = 1'b0;
          hnd_busy   = 1'b0;
        end
      end
      OP_DEC_END: begin
        if (dec_busy) begin
          stamp[2] = w.timestamp_us;
          dec_busy = 1'b0;
          dec_done = !w.failed;
          if (w.failed) bump(ST_ERRORS);
        end
      end
      OP_HND_BEGIN: begin
        if (!dec_done) begin
          bump(ST_UNM_HND);
          hnd_busy = 1'b0;
        end else begin
          stamp[3] = w.timestamp_us;
          dec_done = 1'b0;
          hnd_busy = 1'b1;
        end
      end
      OP_HND_END: begin
        if (hnd_busy) begin
          lat[0] = stamp[1] - stamp[0];
          lat[1] = stamp[2] - stamp[1];
          lat[2] = stamp[3] - stamp[2];
          lat[3] = w.timestamp_us - stamp[3];
          lat[4] = w.timestamp_us - stamp[0];
          for (int k = 0; k < NUM_LAT; k++) begin
            stat_acc[ST_SUM_BASE + k] = stat_acc[ST_SUM_BASE + k] + {32'b0, lat[k]};
            if (lat[k] > stat_acc[ST_MAX_BASE + k][31:0])
              stat_acc[ST_MAX_BASE + k] = {32'b0, lat[k]};
          end
          bump(ST_FRAMES);
          if (lat[4] > cfg_slow_a) bump(ST_SLOW_A);
          if (lat[4] > cfg_slow_b) bump(ST_SLOW_B);
          hnd_busy = 1'b0;
        end
      end
      OP_REPORT: begin
        for (int i = 0; i < NUM_STATS; i++) begin
          sw.stat_index = i[IDX_W-1:0];
          sw.stat_value = typed_now ? typed_stats[i] : stat_acc[i];
          sw.last_item  = (i == ST_SLOW_B);
          stat_words_due.push_back(sw);
        end
        for (int i = 0; i < NUM_STATS; i++) stat_acc[i] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (stat_words_due.size() == 0) begin
      flag_mismatch($sformatf("stat word idx %0d with nothing due", got.stat_index));
    end else begin
      want = stat_words_due.pop_front();
      if (got.stat_index !== want.stat_index)
        flag_mismatch($sformatf("stat_index %0d, want %0d", got.stat_index, want.stat_index));
      if (got.stat_value !== want.stat_value)
        flag_mismatch($sformatf("stat %0d value %0h, want %0h", want.stat_index,
                                got.stat_value, want.stat_value));
      if (got.last_item !== want.last_item)
        flag_mismatch($sformatf("stat %0d last_item %b, want %b", want.stat_index,
                                got.last_item, want.last_item));
    end
  endtask

  // results first, then the word accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_word(out_word);
      if (in_valid && in_ready) profile_event(in_word);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_word(in_word_t w);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    while (stat_words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(logic [15:0] min_bytes, logic [TS_W-1:0] slow_a,
                            logic [TS_W-1:0] slow_b);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PAYLOAD_MIN;
    cfg_wdata <= {16'b0, min_bytes};
    @(negedge clk);
    cfg_addr  <= CFG_SLOW_A;
    cfg_wdata <= slow_a;
    @(negedge clk);
    cfg_addr  <= CFG_SLOW_B;
    cfg_wdata <= slow_b;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_min_bytes = min_bytes;
    cfg_slow_a    = slow_a;
    cfg_slow_b    = slow_b;
  endtask

  task automatic plan_add(in_word_t w);
    plan[plan_len] = '{w: w, typed: 1'b0, stats: '0};
    plan_len++;
  endtask

  function automatic logic [TS_W-1:0] advance_clock_us();
    if ($urandom_range(0, 15) == 0) now_us = now_us + $urandom;
    else now_us = now_us + $urandom_range(0, 9000);
    return now_us;
  endfunction

  // mostly whole frames with random timing; some stages dropped, some noise
  task automatic run_traffic(int n_items);
    int       sent;
    int       pick;
    in_word_t w;
    logic [15:0] req;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (cfg_min_bytes == 16'hFFFF) req = 16'($urandom);
        else req = 16'($urandom_range(int'(cfg_min_bytes) + 1, 65535));
        offer_word(ev(OP_RECV, advance_clock_us(), req, 16'($urandom_range(1, 32767)),
                      1'b1, 1'($urandom_range(0, 1))));
        sent++;
        if ($urandom_range(0, 19) != 0) begin
          offer_word(ev(OP_DEC_BEGIN, advance_clock_us(), 16'($urandom), 16'($urandom),
                        1'b0, 1'b0));
          sent++;
        end
        if ($urandom_range(0, 19) != 0) begin
          offer_word(ev(OP_DEC_END, advance_clock_us(), 16'($urandom), 16'($urandom), 1'b0,
                        $urandom_range(0, 7) == 0));
          sent++;
        end
        if ($urandom_range(0, 19) != 0) begin
          offer_word(ev(OP_HND_BEGIN, advance_clock_us(), 16'($urandom), 16'($urandom),
                        1'b0, 1'b0));
          sent++;
        end
        offer_word(ev(OP_HND_END, advance_clock_us(), 16'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        sent++;
      end else if (pick < 82) begin
        offer_word(ev(OP_REPORT, $urandom, 16'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        sent++;
      end else begin
        w = ev(3'($urandom_range(0, 7)), $urandom, 16'($urandom), 16'($urandom),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        offer_word(w);
        if (w.operation <= OP_REPORT) sent++;
      end
    end
    offer_word(ev(OP_REPORT, advance_clock_us(), '0, '0, 1'b0, 1'b0));
    in_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_STATS; i++) stat_acc[i] = '0;
    for (int i = 0; i < 4; i++) stamp[i] = '0;

    plan_add(ev(OP_REPORT,    32'd5,   16'd0, 16'd0, 1'b0, 1'b0));
    plan[plan_len-1].typed = 1'b1;                  // all zero after reset
    plan_add(ev(OP_DEC_END,   32'd10,  16'd0, 16'd0, 1'b0, 1'b0));   // not decrypting
    plan_add(ev(OP_HND_END,   32'd11,  16'd0, 16'd0, 1'b0, 1'b0));   // no handover
    plan_add(ev(OP_DEC_BEGIN, 32'd12,  16'd0, 16'd0, 1'b0, 1'b0));   // nothing pending
    plan_add(ev(OP_HND_BEGIN, 32'd13,  16'd0, 16'd0, 1'b0, 1'b0));   // not ready
    plan_add(ev(OP_RECV,      32'd0,   16'd200, 16'd5, 1'b1, 1'b0)); // time zero: none
    plan_add(ev(OP_DEC_BEGIN, 32'd20,  16'd0, 16'd0, 1'b0, 1'b0));
    plan_add(ev(OP_REPORT,    32'd21,  16'd0, 16'd0, 1'b0, 1'b0));
    plan[plan_len-1].typed = 1'b1;
    plan[plan_len-1].stats[ST_UNM_DEC] = 64'd2;
    plan[plan_len-1].stats[ST_UNM_HND] = 64'd1;
    // receives that must not register
    plan_add(ev(OP_RECV,      32'd100, 16'd128, 16'd5, 1'b1, 1'b0));
    plan_add(ev(OP_RECV,      32'd100, 16'd0, 16'h7FFF, 1'b1, 1'b0));
    plan_add(ev(OP_RECV,      32'd100, 16'd129, 16'd0, 1'b1, 1'b0));
    plan_add(ev(OP_RECV,      32'd100, 16'd129, 16'h8000, 1'b1, 1'b0));
    plan_add(ev(OP_RECV,      32'd100, 16'hFFFF, 16'h7FFF, 1'b0, 1'b0));
    plan_add(ev(OP_DEC_BEGIN, 32'd101, 16'd0, 16'd0, 1'b0, 1'b0));
    // failed decrypt, then handover refused
    plan_add(ev(OP_RECV,      32'd1,   16'hFFFF, 16'd1, 1'b1, 1'b0));
    plan_add(ev(OP_DEC_BEGIN, 32'd0,   16'd0, 16'd0, 1'b0, 1'b0));
    plan_add(ev(OP_DEC_END,   32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, 1'b1));
    plan_add(ev(OP_HND_BEGIN, 32'd3,   16'd0, 16'd0, 1'b0, 1'b0));
    // overwritten frame, then a full one with a wrapped first stage
    plan_add(ev(OP_RECV,      32'd1,   16'd129, 16'd1, 1'b1, 1'b0));
    plan_add(ev(OP_DEC_BEGIN, 32'd0,   16'd0, 16'd0, 1'b0, 1'b0));
    plan_add(ev(OP_RECV,      32'd8,   16'd129, 16'd1, 1'b1, 1'b0));
    plan_add(ev(OP_DEC_BEGIN, 32'd7,   16'd0, 16'd0, 1'b0, 1'b0));
    plan_add(ev(OP_DEC_END,   32'd17,  16'd0, 16'd0, 1'b0, 1'b0));
    plan_add(ev(OP_HND_BEGIN, 32'd27,  16'd0, 16'd0, 1'b0, 1'b0));
    plan_add(ev(OP_HND_END,   32'd40008, 16'd0, 16'd0, 1'b0, 1'b0));
    plan_add(ev(3'd7,         32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    plan_add(ev(OP_REPORT,    32'd40010, 16'd0, 16'd0, 1'b0, 1'b0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < plan_len; k++) begin
      typed_now   <= plan[k].typed;
      typed_stats <= plan[k].stats;
      offer_word(plan[k].w);
    end
    in_valid  <= 1'b0;
    typed_now <= 1'b0;
    settle();

    now_us = $urandom;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          write_regs(16'd0, 32'd0, 32'hFFFF_FFFF);
          run_traffic(60);
        end
        1: begin
          snd_idle_pct = 70;
          rcv_idle_pct = 12;
          write_regs(16'hFFFF, 32'hFFFF_FFFF, 32'd0);
          run_traffic(16);
        end
        2: begin
          write_regs(16'd300, 32'd2000, 32'd40000);
          run_traffic(50);
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          write_regs(16'($urandom_range(0, 1000)), $urandom_range(0, 30000),
                     $urandom_range(10000, 60000));
          run_traffic(60);
        end
      endcase
      settle();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
